// ===== rtl/bba_pkg.sv =====
// Shared types and constants for the buddy block allocator.
package bba_pkg;

  localparam int LOG_W   = 5;
  localparam int ENTRY_W = LOG_W + 1;
  localparam int REQ_W   = 26;
  localparam int PROD_W  = 51;

  localparam logic       CFG_REGION_LOG2  = 1'b0;
  localparam logic       CFG_HEADER_BYTES = 1'b1;
  localparam logic       KIND_ALLOC       = 1'b0;
  localparam logic       KIND_FREE        = 1'b1;
  localparam logic [4:0] REGION_RST       = 5'd16;
  localparam logic [4:0] HEADER_RST       = 5'd16;

  typedef struct packed {
    logic        kind;
    logic [24:0] elem_size;
    logic [24:0] elem_count;
    logic [23:0] free_offset;
  } in_t;

  typedef struct packed {
    logic [23:0] data_offset;
    logic        ok;
  } out_t;

endpackage

// ===== rtl/bba_ram.sv =====
// Generic single-port-write, registered-read RAM.
module bba_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 2048
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/buddy_block_allocator.sv =====
// Top level: buddy tree allocator with slot table RAM and scan sequencer.
// Sequence: allocate multiplies the low digit then the high digit of the count, then each
// scan or coalescing pass walks the block chain (up to 2^(MAX_REGION_LOG2-MIN_BLOCK_LOG2)
// blocks per pass), splits the chosen block and finishes; free walks the chain block by
// block, then coalesces the same way.
// Throughput: one item at a time. Reset: S_INIT writes slot 0 as the whole region free.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int MIN_BLOCK_LOG2  = 5,
  parameter int MAX_REGION_LOG2 = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam int CAP   = (MAX_REGION_LOG2 > MIN_BLOCK_LOG2) ? MAX_REGION_LOG2 : MIN_BLOCK_LOG2;
  localparam int OW    = CAP + 1;
  localparam int SLOTS = 1 << (CAP - MIN_BLOCK_LOG2);
  localparam int SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_MUL1   = 5'd2;
  localparam logic [4:0] S_MUL2   = 5'd3;
  localparam logic [4:0] S_FSTART = 5'd4;
  localparam logic [4:0] S_FS0    = 5'd5;
  localparam logic [4:0] S_LCHK   = 5'd6;
  localparam logic [4:0] S_LRB    = 5'd7;
  localparam logic [4:0] S_LRD    = 5'd8;
  localparam logic [4:0] S_LNB    = 5'd9;
  localparam logic [4:0] S_LNB2   = 5'd10;
  localparam logic [4:0] S_LEND   = 5'd11;
  localparam logic [4:0] S_SPRD   = 5'd12;
  localparam logic [4:0] S_SPGET  = 5'd13;
  localparam logic [4:0] S_SPLOOP = 5'd14;
  localparam logic [4:0] S_SPW2   = 5'd15;
  localparam logic [4:0] S_FRCHK  = 5'd16;
  localparam logic [4:0] S_FRADV  = 5'd17;
  localparam logic [4:0] S_FRMARK = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  function automatic logic fits(input logic [REQ_W-1:0] r, input logic [LOG_W-1:0] l);
    return r <= (REQ_W'(1) << l);
  endfunction

  logic [4:0]        state_r, state_nxt;
  logic [4:0]        region_r, header_r;
  logic              op_free_r, op_free_nxt;
  logic              retry_r, retry_nxt;
  logic              coal_r, coal_nxt;
  logic              none_r, none_nxt;
  logic              have_r, have_nxt;
  logic [OW-1:0]     blk_r, blk_nxt, bud_r, bud_nxt, best_r, best_nxt;
  logic [LOG_W-1:0]  best_log_r, best_log_nxt;
  logic [LOG_W-1:0]  lb_r, lb_nxt;
  logic              fb_r, fb_nxt;
  logic [OW-1:0]     sp_off_r, sp_off_nxt;
  logic [LOG_W-1:0]  sp_log_r, sp_log_nxt;
  logic              sp_free_r, sp_free_nxt;
  logic [24:0]       a_r, a_nxt, b_r, b_nxt, target_r, target_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  out_t              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic                ram_we;
  logic [SAW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, rd_q;
  logic [LOG_W-1:0]    rd_log;
  logic                rd_free;
  logic [LOG_W-1:0]    eff_log;
  logic [OW-1:0]       tail;
  logic [12:0]         mul_b;
  logic [37:0]         mul_p;
  logic [PROD_W-1:0]   prod_sum;
  logic [OW-1:0]       sz_ld, bud_end, merge_end;
  logic [LOG_W-1:0]    ml;
  logic                h1;
  logic [OW-1:0]       b1;
  logic [LOG_W-1:0]    bl1;

  assign rd_log  = rd_q[LOG_W-1:0];
  assign rd_free = rd_q[LOG_W];

  // Clamp the region size into the supported range
  always_comb begin
    if (region_r > LOG_W'(CAP)) begin
      eff_log = LOG_W'(CAP);
    end else if (region_r < LOG_W'(MIN_BLOCK_LOG2)) begin
      eff_log = LOG_W'(MIN_BLOCK_LOG2);
    end else begin
      eff_log = region_r;
    end
  end
  assign tail = OW'(1) << eff_log;

  // Shared multiplier: low digit of the count first, then the high digit
  assign mul_b    = (state_r == S_MUL1) ? b_r[12:0] : {1'b0, b_r[24:13]};
  assign mul_p    = 38'(a_r) * 38'(mul_b);
  assign prod_sum = acc_r + (PROD_W'(mul_p) << 13) + PROD_W'(header_r);

  // Scan helpers
  assign sz_ld     = OW'(1) << rd_log;
  assign bud_end   = bud_r + sz_ld;
  assign ml        = lb_r + LOG_W'(1);
  assign merge_end = blk_r + (OW'(1) << ml);

  // Best-fit candidates from the block then its neighbor
  always_comb begin
    h1  = have_r;
    b1  = best_r;
    bl1 = best_log_r;
    if (fb_r && fits(req_r, lb_r) && (!have_r || lb_r < best_log_r)) begin
      h1  = 1'b1;
      b1  = blk_r;
      bl1 = lb_r;
    end
  end

  bba_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_q)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_free_nxt   = op_free_r;
    retry_nxt     = retry_r;
    coal_nxt      = coal_r;
    none_nxt      = none_r;
    have_nxt      = have_r;
    blk_nxt       = blk_r;
    bud_nxt       = bud_r;
    best_nxt      = best_r;
    best_log_nxt  = best_log_r;
    lb_nxt        = lb_r;
    fb_nxt        = fb_r;
    sp_off_nxt    = sp_off_r;
    sp_log_nxt    = sp_log_r;
    sp_free_nxt   = sp_free_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    target_nxt    = target_r;
    acc_nxt       = acc_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, eff_log};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          a_nxt       = in_data.elem_size;
          b_nxt       = in_data.elem_count;
          op_free_nxt = (in_data.kind == KIND_FREE);
          retry_nxt   = 1'b0;
          coal_nxt    = 1'b0;
          res_nxt     = '0;
          if (in_data.kind == KIND_ALLOC) begin
            state_nxt = S_MUL1;
          end else if (in_data.free_offset >= 24'(header_r)) begin
            target_nxt = 25'(in_data.free_offset - 24'(header_r));
            blk_nxt    = '0;
            state_nxt  = S_FRCHK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL1: begin
        acc_nxt   = PROD_W'(mul_p);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        // Saturate: a product of 2^25 or more fits no block
        if (|prod_sum[PROD_W-1:REQ_W-1]) begin
          req_nxt = '1;
        end else begin
          req_nxt = prod_sum[REQ_W-1:0];
        end
        state_nxt = S_FSTART;
      end
      S_FSTART: begin
        ram_raddr = '0;
        state_nxt = S_FS0;
      end
      S_FS0: begin
        blk_nxt  = '0;
        bud_nxt  = sz_ld;
        have_nxt = 1'b0;
        none_nxt = 1'b1;
        if (!coal_r && sz_ld == tail && rd_free) begin
          sp_off_nxt  = '0;
          sp_log_nxt  = rd_log;
          sp_free_nxt = rd_free;
          state_nxt   = S_SPLOOP;
        end else begin
          state_nxt = S_LCHK;
        end
      end
      S_LCHK: begin
        if (blk_r < tail && bud_r < tail) begin
          ram_raddr = SAW'(blk_r >> MIN_BLOCK_LOG2);
          state_nxt = S_LRB;
        end else begin
          state_nxt = S_LEND;
        end
      end
      S_LRB: begin
        lb_nxt    = rd_log;
        fb_nxt    = rd_free;
        ram_raddr = SAW'(bud_r >> MIN_BLOCK_LOG2);
        state_nxt = S_LRD;
      end
      S_LRD: begin
        if (coal_r) begin
          // Coalescing pass
          if (lb_r < rd_log) begin
            blk_nxt   = bud_end;
            state_nxt = S_LNB;
          end else if (lb_r > rd_log) begin
            blk_nxt   = bud_r;
            bud_nxt   = bud_end;
            state_nxt = S_LCHK;
          end else if (fb_r && rd_free) begin
            ram_we    = 1'b1;
            ram_waddr = SAW'(blk_r >> MIN_BLOCK_LOG2);
            ram_wdata = {1'b1, ml};
            blk_nxt   = merge_end;
            if (merge_end < tail) begin
              none_nxt = 1'b0;
            end
            state_nxt = S_LNB;
          end else begin
            blk_nxt   = bud_end;
            state_nxt = S_LNB;
          end
        end else if (fb_r && rd_free && lb_r == rd_log) begin
          // Merge on the way and consider the merged block
          ram_we    = 1'b1;
          ram_waddr = SAW'(blk_r >> MIN_BLOCK_LOG2);
          ram_wdata = {1'b1, ml};
          if (fits(req_r, ml) && (!have_r || best_r == blk_r || ml <= best_log_r)) begin
            have_nxt     = 1'b1;
            best_nxt     = blk_r;
            best_log_nxt = ml;
          end
          blk_nxt   = bud_end;
          state_nxt = S_LNB;
        end else begin
          have_nxt     = h1;
          best_nxt     = b1;
          best_log_nxt = bl1;
          if (rd_free && fits(req_r, rd_log) && (!h1 || rd_log < bl1)) begin
            have_nxt     = 1'b1;
            best_nxt     = bud_r;
            best_log_nxt = rd_log;
          end
          if (lb_r < rd_log) begin
            blk_nxt   = bud_end;
            state_nxt = S_LNB;
          end else begin
            blk_nxt   = bud_r;
            bud_nxt   = bud_end;
            state_nxt = S_LCHK;
          end
        end
      end
      S_LNB: begin
        ram_raddr = SAW'(blk_r >> MIN_BLOCK_LOG2);
        state_nxt = S_LNB2;
      end
      S_LNB2: begin
        if (blk_r < tail) begin
          bud_nxt = blk_r + sz_ld;
        end
        state_nxt = S_LCHK;
      end
      S_LEND: begin
        if (coal_r) begin
          if (!none_r) begin
            state_nxt = S_FSTART;
          end else if (op_free_r) begin
            res_nxt.ok = 1'b1;
            state_nxt  = S_DONE;
          end else begin
            coal_nxt  = 1'b0;
            state_nxt = S_FSTART;
          end
        end else if (have_r) begin
          sp_off_nxt = best_r;
          state_nxt  = S_SPRD;
        end else if (!retry_r) begin
          retry_nxt = 1'b1;
          coal_nxt  = 1'b1;
          state_nxt = S_FSTART;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SPRD: begin
        ram_raddr = SAW'(sp_off_r >> MIN_BLOCK_LOG2);
        state_nxt = S_SPGET;
      end
      S_SPGET: begin
        sp_log_nxt  = rd_log;
        sp_free_nxt = rd_free;
        state_nxt   = S_SPLOOP;
      end
      S_SPLOOP: begin
        if (({req_r, 1'b0} < ((REQ_W + 1)'(1) << sp_log_r)) &&
            (sp_log_r > LOG_W'(MIN_BLOCK_LOG2))) begin
          // Halve and keep the upper half
          ram_we     = 1'b1;
          ram_waddr  = SAW'(sp_off_r >> MIN_BLOCK_LOG2);
          ram_wdata  = {sp_free_r, sp_log_r - LOG_W'(1)};
          sp_off_nxt = sp_off_r + (OW'(1) << (sp_log_r - LOG_W'(1)));
          sp_log_nxt = sp_log_r - LOG_W'(1);
          state_nxt  = S_SPW2;
        end else if (fits(req_r, sp_log_r)) begin
          ram_we              = 1'b1;
          ram_waddr           = SAW'(sp_off_r >> MIN_BLOCK_LOG2);
          ram_wdata           = {1'b0, sp_log_r};
          res_nxt.data_offset = 24'(25'(sp_off_r) + 25'(header_r));
          res_nxt.ok          = 1'b1;
          state_nxt           = S_DONE;
        end else if (!retry_r) begin
          retry_nxt = 1'b1;
          coal_nxt  = 1'b1;
          state_nxt = S_FSTART;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SPW2: begin
        ram_we      = 1'b1;
        ram_waddr   = SAW'(sp_off_r >> MIN_BLOCK_LOG2);
        ram_wdata   = {1'b1, sp_log_r};
        sp_free_nxt = 1'b1;
        state_nxt   = S_SPLOOP;
      end
      S_FRCHK: begin
        // Walk the chain to the freed block
        if (blk_r >= tail) begin
          state_nxt = S_DONE;
        end else begin
          ram_raddr = SAW'(blk_r >> MIN_BLOCK_LOG2);
          state_nxt = (25'(blk_r) == target_r) ? S_FRMARK : S_FRADV;
        end
      end
      S_FRADV: begin
        blk_nxt   = blk_r + sz_ld;
        state_nxt = S_FRCHK;
      end
      S_FRMARK: begin
        ram_we    = 1'b1;
        ram_waddr = SAW'(blk_r >> MIN_BLOCK_LOG2);
        ram_wdata = {1'b1, rd_log};
        coal_nxt  = 1'b1;
        state_nxt = S_FSTART;
      end
      S_DONE: begin
        // Hand the beat to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we && cfg_index == CFG_REGION_LOG2) begin
      state_nxt = S_INIT;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      region_r    <= REGION_RST;
      header_r    <= HEADER_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_REGION_LOG2) begin
        region_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_HEADER_BYTES) begin
        header_r <= cfg_wdata;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_free_r  <= op_free_nxt;
    retry_r    <= retry_nxt;
    coal_r     <= coal_nxt;
    none_r     <= none_nxt;
    have_r     <= have_nxt;
    blk_r      <= blk_nxt;
    bud_r      <= bud_nxt;
    best_r     <= best_nxt;
    best_log_r <= best_log_nxt;
    lb_r       <= lb_nxt;
    fb_r       <= fb_nxt;
    sp_off_r   <= sp_off_nxt;
    sp_log_r   <= sp_log_nxt;
    sp_free_r  <= sp_free_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    target_r   <= target_nxt;
    acc_r      <= acc_nxt;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
